@@ design/assert_macros.svh @@
// Assertion macros for the checker file of this project.
// No dependencies; take it in with a plain include of the file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// An implication: when ante holds, cons holds in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// An implication: when ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/afs_pkg.sv @@
// Package for the ADTS frame synchronizer: constants, types and the rate table.
// No dependencies; used by every module of the block.
package afs_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int WIN_LEN           = 7;
    localparam int FILL_W            = $clog2(WIN_LEN + 1);

    localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
    localparam logic [7:0]  ID_MASK        = 8'hF6;
    localparam logic [7:0]  ID_MATCH       = 8'hF0;
    localparam logic [3:0]  MAX_RATE_IDX   = 4'd11;
    localparam logic [12:0] MIN_FRAME_LEN  = 13'd8;
    localparam logic [3:0]  LOCK_COUNT_RST = 4'd3;
    localparam logic [3:0]  RUN_MAX        = 4'd15;

    localparam int OUT_TDATA_W = 72;

    // Result kinds carried on the master tuser bit.
    localparam logic EVT_HEADER    = 1'b0;
    localparam logic EVT_SYNC_LOST = 1'b1;

    // Byte [0] is the oldest byte of the window.
    typedef logic [WIN_LEN-1:0][7:0] window_t;

    typedef struct packed {
        logic        valid;
        logic [16:0] rate;
        logic [12:0] len;
        logic [2:0]  blocks;
    } hdr_info_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] pos;
        logic [16:0] rate;
        logic [12:0] len;
        logic [2:0]  blocks;
        logic [3:0]  run;
        logic        locked;
    } result_t;

    function automatic logic [16:0] rate_lookup(input logic [3:0] idx);
        logic [16:0] rate;
        unique case (idx)
            4'd0:    rate = 17'd96000;
            4'd1:    rate = 17'd88200;
            4'd2:    rate = 17'd64000;
            4'd3:    rate = 17'd48000;
            4'd4:    rate = 17'd44100;
            4'd5:    rate = 17'd32000;
            4'd6:    rate = 17'd24000;
            4'd7:    rate = 17'd22050;
            4'd8:    rate = 17'd16000;
            4'd9:    rate = 17'd12000;
            4'd10:   rate = 17'd11025;
            4'd11:   rate = 17'd8000;
            default: rate = 17'd0;
        endcase
        return rate;
    endfunction

endpackage

@@ design/afs_hdr_decode.sv @@
// Header decoder: tests a 7-byte window for a valid ADTS header and extracts fields.
// Depends on afs_pkg.
module afs_hdr_decode (
    input  afs_pkg::window_t   win,
    output afs_pkg::hdr_info_t info
);
    import afs_pkg::*;

    logic [3:0]  rate_idx;
    logic [12:0] frame_len;
    logic        id_ok;

    assign rate_idx  = win[2][5:2];
    assign frame_len = {win[3][1:0], win[4], win[5][7:5]};
    assign id_ok     = (win[0] == SYNC_BYTE) && ((win[1] & ID_MASK) == ID_MATCH);

    always_comb
    begin
        info.valid  = id_ok && (rate_idx <= MAX_RATE_IDX) && (frame_len >= MIN_FRAME_LEN);
        info.rate   = rate_lookup(rate_idx);
        info.len    = frame_len;
        info.blocks = {1'b0, win[6][1:0]} + 3'd1;
    end

endmodule

@@ design/afs_sync_core.sv @@
// Sync core: byte window, hunt/track state, lock register and the result register.
// Depends on afs_pkg and afs_hdr_decode.
module afs_sync_core #(
    parameter int POSITION_BITS = afs_pkg::POSITION_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [7:0]       data_byte,
    input  logic             restart,
    input  logic             cfg_we,
    input  logic [3:0]       cfg_wdata,
    input  logic             res_ready,
    output logic             res_valid,
    output logic             can_take,
    output afs_pkg::result_t res
);
    import afs_pkg::*;

    window_t                  win_reg, win_next;
    logic [FILL_W-1:0]        fill_reg, fill_next, fill_base;
    logic                     trk_reg, trk_next, trk_base;
    logic [12:0]              btb_reg, btb_next, btb_base, btb_dec;
    logic [3:0]               run_reg, run_next, run_base;
    logic [POSITION_BITS-1:0] spos_reg, spos_next, spos_base, hdr_pos;
    logic [63:0]              hdr_pos_ext;
    logic [3:0]               lock_reg;
    logic                     out_vld_reg, out_vld_next;
    result_t                  res_reg, res_next;
    hdr_info_t                info;
    logic                     full, test;

    afs_hdr_decode u_decode (
        .win  (win_next),
        .info (info)
    );

    assign can_take  = !out_vld_reg || res_ready;
    assign res_valid = out_vld_reg;
    assign res       = res_reg;

    always_comb
    begin
        // A restart clears the stream state ahead of this byte. The window
        // itself needs no clear: nothing is tested until it has refilled.
        fill_base = restart ? '0 : fill_reg;
        trk_base  = restart ? 1'b0 : trk_reg;
        btb_base  = restart ? '0 : btb_reg;
        run_base  = restart ? '0 : run_reg;
        spos_base = restart ? '0 : spos_reg;

        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            win_next[i] = win_reg[i+1];
        end
        win_next[WIN_LEN-1] = data_byte;

        fill_next   = (fill_base < FILL_W'(WIN_LEN)) ? fill_base + 1'b1 : fill_base;
        full        = (fill_next == FILL_W'(WIN_LEN));
        hdr_pos     = spos_base - POSITION_BITS'(WIN_LEN - 1);
        hdr_pos_ext = 64'(hdr_pos);
        spos_next   = spos_base + 1'b1;
        btb_dec     = btb_base - 13'd1;

        trk_next     = trk_base;
        btb_next     = btb_base;
        run_next     = run_base;
        test         = 1'b0;
        out_vld_next = out_vld_reg && !res_ready;
        res_next     = res_reg;

        if (full)
        begin
            if (trk_base)
            begin
                btb_next = btb_dec;
                test     = (btb_dec == 13'd0);
            end
            else
            begin
                test = 1'b1;
            end
        end

        if (go)
        begin
            out_vld_next = 1'b0;
        end

        if (test && info.valid)
        begin
            run_next = !trk_base ? 4'd1 : ((run_base < RUN_MAX) ? run_base + 4'd1 : run_base);
            trk_next = 1'b1;
            btb_next = info.len;
            res_next.kind   = EVT_HEADER;
            res_next.pos    = hdr_pos_ext[31:0];
            res_next.rate   = info.rate;
            res_next.len    = info.len;
            res_next.blocks = info.blocks;
            res_next.run    = run_next;
            res_next.locked = (run_next >= lock_reg);
            if (go)
            begin
                out_vld_next = 1'b1;
            end
        end
        else if (test && trk_base)
        begin
            // Expected boundary held no header: report and go back to hunting.
            trk_next = 1'b0;
            run_next = '0;
            btb_next = '0;
            res_next        = '0;
            res_next.kind   = EVT_SYNC_LOST;
            res_next.pos    = hdr_pos_ext[31:0];
            if (go)
            begin
                out_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            trk_reg     <= 1'b0;
            btb_reg     <= '0;
            run_reg     <= '0;
            spos_reg    <= '0;
            lock_reg    <= LOCK_COUNT_RST;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                lock_reg <= cfg_wdata;
            end
            if (go)
            begin
                fill_reg <= fill_next;
                trk_reg  <= trk_next;
                btb_reg  <= btb_next;
                run_reg  <= run_next;
                spos_reg <= spos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            win_reg <= win_next;
            res_reg <= res_next;
        end
    end

endmodule

@@ design/adts_frame_sync.sv @@
// Top level of the ADTS frame synchronizer: stream ports, input register, sync core.
// Depends on afs_pkg and afs_sync_core.
//
// The block takes one byte per slave transaction and sustains one byte per clock
// cycle while the master side takes results. Each byte goes into an input
// register; when the output register has room, the sync core shifts it into a
// 7-byte window, tests the window for an ADTS header and loads any result into
// the output register, from which it is offered on the master side. While
// hunting, every full window is tested; once a header is found only the window
// that starts exactly one frame length later is tested.
// A valid header gives a result with event kind 0; a miss at the expected boundary
// gives event kind 1 (sync lost) with all fields but the position zero, and the
// block hunts again from the next byte. The first six bytes after reset or a
// restart only fill the window and give no result. Setting the restart flag on a
// byte clears the fill count, position and tracking state before that byte enters.
// Header positions count bytes since the last restart and wrap. The lock count
// register (reset value 3) sets how many aligned headers are needed before the
// locked flag rises; write it only while no byte is in flight. The only stall
// comes from the master side: the slave side stops only when the output register
// holds a result that has not been taken.
module adts_frame_sync #(
    parameter int POSITION_BITS = afs_pkg::POSITION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Slave stream: one byte per transaction.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [7:0] data_byte
    input  logic                             s_tuser,  // [0] restart
    // Master stream: one result per transaction.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] header_position, [48:32] sample_rate, [61:49] frame_length,
    // [64:62] raw_blocks, [68:65] run_count, [69] locked, [71:70] zero
    output logic [afs_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tuser,  // [0] event_kind
    // Configuration: lock_count.
    input  logic                             cfg_we,
    input  logic [3:0]                       cfg_wdata
);
    import afs_pkg::*;

    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_restart_reg;
    logic       can_take;
    logic       go;
    logic       accept;
    result_t    res;

    // The held byte moves into the core when the output register has room,
    // which frees the input register for a new transaction in the same cycle.
    assign go          = in_vld_reg && can_take;
    assign s_tready    = !in_vld_reg || go;
    assign accept      = s_tvalid && s_tready;
    assign in_vld_next = accept || (in_vld_reg && !go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
    end

    afs_sync_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .data_byte (in_byte_reg),
        .restart   (in_restart_reg),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res_ready (m_tready),
        .res_valid (m_tvalid),
        .can_take  (can_take),
        .res       (res)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {2'b00, res.locked, res.run, res.blocks, res.len, res.rate, res.pos};

endmodule

@@ design/afs_checker.sv @@
// Port-level checker for the ADTS frame synchronizer, bound to the top level.
// Depends on assert_macros.svh and afs_pkg.
`include "assert_macros.svh"

module afs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [afs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);
    import afs_pkg::*;

    // A stalled result holds its payload.
    `ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A sync lost result carries only the position.
    `ASSERT_IMPLY(a_lost_zero, clk, rst_n, m_tvalid && (m_tuser == EVT_SYNC_LOST),
        m_tdata[71:32] == 40'd0)

    // A header result has a sane length, block count and run count.
    `ASSERT_IMPLY(a_hdr_fields, clk, rst_n, m_tvalid && (m_tuser == EVT_HEADER),
        (m_tdata[61:49] >= MIN_FRAME_LEN) && (m_tdata[64:62] != 3'd0)
        && (m_tdata[68:65] != 4'd0) && (m_tdata[71:70] == 2'd0))

    // A saturated run is always at or above any lock count.
    `ASSERT_IMPLY(a_sat_locked, clk, rst_n,
        m_tvalid && (m_tuser == EVT_HEADER) && (m_tdata[68:65] == RUN_MAX), m_tdata[69])

endmodule

bind adts_frame_sync afs_checker u_afs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ verif/tb_adts_frame_sync.sv @@
// Self-checking testbench for adts_frame_sync: drives byte streams that hold ADTS frames
// and checks every header and sync-lost result against a predictor of its own.
// Depends on afs_pkg and the adts_frame_sync RTL.
module tb_adts_frame_sync;

    import afs_pkg::*;

    localparam int LONG_HOLD_CYCLES = 500;

    // Sampling rates indexed by the 4-bit rate field of the header.
    localparam logic [16:0] RATE_HZ [12] = '{
        17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
        17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000
    };

    // Ways to spoil an otherwise well-formed header.
    typedef enum int unsigned {
        FLAW_SYNC,
        FLAW_ID,
        FLAW_RATE,
        FLAW_LENGTH
    } flaw_t;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } stream_byte_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'h00;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_we = 1'b0;
    logic [3:0]             cfg_wdata = 4'd0;

    adts_frame_sync dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Bytes waiting to be offered, and the results they are predicted to cause.
    stream_byte_t bytes_to_send [$];
    result_t      events_due [$];
    int unsigned  bytes_queued = 0;
    int unsigned  mismatch_count = 0;

    // Idle behavior of both sides, changed from phase to phase.
    int unsigned  sender_idle_pct = 0;
    int unsigned  receiver_idle_pct = 0;
    logic         hold_request = 1'b0;
    logic         hold_receiver = 1'b0;

    // Predictor state: the byte window and the tracking state of the synchronizer.
    logic [7:0]   hdr_window [7];
    logic [2:0]   seen_bytes = 3'd0;
    logic         in_track = 1'b0;
    logic [12:0]  until_next_hdr = 13'd0;
    logic [3:0]   aligned_run = 4'd0;
    logic [31:0]  byte_offset = 32'd0;
    logic [3:0]   lock_setting = LOCK_COUNT_RST;

    initial begin
        foreach (hdr_window[i])
            hdr_window[i] = 8'h00;
    end

    // Advances the predicted synchronizer by one byte and queues any result it causes.
    function automatic void track_byte(input logic [7:0] data_byte, input logic restart);
        result_t     res;
        logic [3:0]  idx;
        logic [12:0] len;
        logic [31:0] tested_pos;
        logic        tested;
        logic        hdr_ok;
        if (restart) begin
            foreach (hdr_window[i])
                hdr_window[i] = 8'h00;
            seen_bytes = 3'd0;
            in_track = 1'b0;
            until_next_hdr = 13'd0;
            aligned_run = 4'd0;
            byte_offset = 32'd0;
        end
        for (int i = 0; i < 6; i++)
            hdr_window[i] = hdr_window[i + 1];
        hdr_window[6] = data_byte;
        if (seen_bytes < 3'd7)
            seen_bytes = seen_bytes + 3'd1;
        tested_pos = byte_offset - 32'd6;
        byte_offset = byte_offset + 32'd1;
        if (seen_bytes < 3'd7)
            return;

        // While tracking, only the window one frame length on is examined.
        tested = 1'b1;
        if (in_track) begin
            until_next_hdr = until_next_hdr - 13'd1;
            tested = (until_next_hdr == 13'd0);
        end
        if (!tested)
            return;

        idx = hdr_window[2][5:2];
        len = {hdr_window[3][1:0], hdr_window[4], hdr_window[5][7:5]};
        hdr_ok = (hdr_window[0] == SYNC_BYTE) && ((hdr_window[1] & ID_MASK) == ID_MATCH)
            && (idx <= MAX_RATE_IDX) && (len >= MIN_FRAME_LEN);

        res = '0;
        res.pos = tested_pos;
        if (!hdr_ok) begin
            // A miss while hunting is silent; a miss at the boundary drops sync.
            if (!in_track)
                return;
            in_track = 1'b0;
            aligned_run = 4'd0;
            until_next_hdr = 13'd0;
            res.kind = EVT_SYNC_LOST;
            events_due.push_back(res);
            return;
        end

        if (in_track) begin
            if (aligned_run < RUN_MAX)
                aligned_run = aligned_run + 4'd1;
        end else begin
            aligned_run = 4'd1;
            in_track = 1'b1;
        end
        until_next_hdr = len;

        res.kind = EVT_HEADER;
        res.rate = RATE_HZ[idx];
        res.len = len;
        res.blocks = {1'b0, hdr_window[6][1:0]} + 3'd1;
        res.run = aligned_run;
        res.locked = (aligned_run >= lock_setting);
        events_due.push_back(res);
    endfunction

    task automatic flag_mismatch(input string what, input logic [71:0] got,
                                 input logic [71:0] want);
        mismatch_count++;
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Compares one result transaction with the oldest predicted result.
    task automatic check_event(input logic kind, input logic [OUT_TDATA_W-1:0] word);
        result_t want;
        if (events_due.size() == 0) begin
            flag_mismatch("result with none expected", word, '0);
            return;
        end
        want = events_due.pop_front();
        if (kind !== want.kind)
            flag_mismatch("event_kind", kind, want.kind);
        if (word[31:0] !== want.pos)
            flag_mismatch("header_position", word[31:0], want.pos);
        if (word[48:32] !== want.rate)
            flag_mismatch("sample_rate", word[48:32], want.rate);
        if (word[61:49] !== want.len)
            flag_mismatch("frame_length", word[61:49], want.len);
        if (word[64:62] !== want.blocks)
            flag_mismatch("raw_blocks", word[64:62], want.blocks);
        if (word[68:65] !== want.run)
            flag_mismatch("run_count", word[68:65], want.run);
        if (word[69] !== want.locked)
            flag_mismatch("locked", word[69], want.locked);
        if (word[71:70] !== 2'b00)
            flag_mismatch("tdata padding", word[71:70], 2'b00);
    endtask

    // A gap at the given idle percentage, else none; gaps are mostly short, with an occasional long one.
    function automatic int unsigned random_gap(input int unsigned idle_pct);
        int unsigned r;
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sender: offers queued bytes, holding each until it is taken.
    int unsigned  send_gap = 0;
    stream_byte_t next_byte;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready)
                track_byte(s_tdata, s_tuser);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (bytes_to_send.size() > 0) begin
                    next_byte = bytes_to_send.pop_front();
                    s_tdata <= next_byte.data;
                    s_tuser <= next_byte.restart;
                    s_tvalid <= 1'b1;
                    send_gap <= random_gap(sender_idle_pct);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transaction and stalls at random.
    int unsigned recv_gap = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready)
                check_event(m_tuser, m_tdata);
            if (hold_receiver) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap <= random_gap(receiver_idle_pct);
            end
        end
    end

    // One long receiver hold-off while the sender keeps a dense run of frames coming.
    initial begin
        wait (hold_request);
        @(posedge clk);
        hold_receiver <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_receiver <= 1'b0;
    end

    task automatic push_byte(input logic [7:0] data, input logic restart);
        stream_byte_t b;
        b.data = data;
        b.restart = restart;
        bytes_to_send.push_back(b);
        bytes_queued++;
    endtask

    // A protection-flag and ID byte that passes the header mask.
    function automatic logic [7:0] good_id();
        return ID_MATCH | {4'b0000, 1'($urandom_range(0, 1)), 2'b00, 1'($urandom_range(0, 1))};
    endfunction

    task automatic push_header(input logic [7:0] sync, input logic [7:0] id,
                               input logic [3:0] idx, input logic [12:0] len,
                               input logic [1:0] blocks, input logic restart);
        push_byte(sync, restart);
        push_byte(id, 1'b0);
        push_byte({2'($urandom_range(0, 3)), idx, 2'($urandom_range(0, 3))}, 1'b0);
        push_byte({6'($urandom_range(0, 63)), len[12:11]}, 1'b0);
        push_byte(len[10:3], 1'b0);
        push_byte({len[2:0], 5'($urandom_range(0, 31))}, 1'b0);
        push_byte({6'($urandom_range(0, 63)), blocks}, 1'b0);
    endtask

    task automatic push_frame(input logic [12:0] len, input logic [3:0] idx,
                              input logic [1:0] blocks, input logic restart);
        push_header(SYNC_BYTE, good_id(), idx, len, blocks, restart);
        for (int i = 7; i < len; i++)
            push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic push_any_frame(input logic [12:0] len, input logic restart);
        push_frame(len, 4'($urandom_range(0, 11)), 2'($urandom_range(0, 3)), restart);
    endtask

    // Seven header bytes with exactly one thing wrong.
    task automatic push_flawed_header(input flaw_t flaw);
        logic [7:0]  sync;
        logic [7:0]  id;
        logic [3:0]  idx;
        logic [12:0] len;
        sync = SYNC_BYTE;
        id = good_id();
        idx = 4'($urandom_range(0, 11));
        len = 13'($urandom_range(8, 48));
        case (flaw)
            FLAW_SYNC:   sync = 8'($urandom_range(0, 254));
            FLAW_ID: begin
                while ((id & ID_MASK) == ID_MATCH)
                    id = 8'($urandom_range(0, 255));
            end
            FLAW_RATE:   idx = 4'($urandom_range(12, 15));
            FLAW_LENGTH: len = 13'($urandom_range(0, 7));
            default:     ;
        endcase
        push_header(sync, id, idx, len, 2'($urandom_range(0, 3)), 1'b0);
    endtask

    // Frame lengths stay small so that headers come often; a few are longer.
    function automatic logic [12:0] short_length();
        if ($urandom_range(0, 99) < 95)
            return 13'($urandom_range(8, 48));
        return 13'($urandom_range(49, 200));
    endfunction

    // Mostly runs of aligned frames with random content, with noise, slipped frames,
    // truncated frames and restarts mixed in.
    task automatic random_phase(input int unsigned budget);
        int unsigned mark;
        int unsigned pick;
        int unsigned n;
        mark = bytes_queued;
        while (bytes_queued - mark < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    push_any_frame(short_length(), k == 0 && $urandom_range(0, 99) < 15);
                if ($urandom_range(0, 99) < 45)
                    push_flawed_header(flaw_t'($urandom_range(0, 3)));
            end else if (pick < 80) begin
                n = $urandom_range(1, 20);
                for (int k = 0; k < n; k++)
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 4);
            end else if (pick < 90) begin
                // A stray byte shifts the next header one place past its boundary.
                push_any_frame(short_length(), 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b0);
                push_any_frame(short_length(), 1'b0);
            end else begin
                // A frame cut short, then a new frame with or without a restart.
                push_header(SYNC_BYTE, good_id(), 4'($urandom_range(0, 11)),
                            13'($urandom_range(20, 48)), 2'($urandom_range(0, 3)), 1'b0);
                n = $urandom_range(0, 10);
                for (int k = 0; k < n; k++)
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
                push_any_frame(short_length(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Waits until every byte is taken and every predicted result has arrived, then
    // lets the last bytes, which may cause no result, clear the pipeline.
    task automatic wait_drained();
        while (bytes_to_send.size() != 0 || s_tvalid || events_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_lock_count(input logic [3:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        lock_setting = value;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lock count at its reset value. The first six bytes only fill the window;
        // shortest frames with the rate index and block count at both ends, then a
        // spoiled header at the expected boundary.
        sender_idle_pct = 30;
        receiver_idle_pct = 30;
        push_frame(13'd8, 4'd0, 2'd0, 1'b1);
        push_frame(13'd8, 4'd11, 2'd3, 1'b0);
        push_flawed_header(FLAW_SYNC);
        random_phase(120);
        wait_drained();

        // Lock on the first header. The receiver holds off for a long stretch while
        // a dense run of shortest frames keeps arriving, so the input stalls.
        write_lock_count(4'd1);
        sender_idle_pct = 10;
        receiver_idle_pct = 20;
        hold_request = 1'b1;
        for (int k = 0; k < 16; k++)
            push_any_frame(13'd8, k == 0);
        random_phase(50);
        wait_drained();

        // Highest lock count, no idling on either side, and headers that announce very
        // long frames; a restart follows each, so the long bodies are never sent.
        write_lock_count(4'd15);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        push_header(SYNC_BYTE, good_id(), 4'($urandom_range(0, 11)), 13'd8191,
                    2'($urandom_range(0, 3)), 1'b1);
        push_header(SYNC_BYTE, good_id(), 4'($urandom_range(0, 11)),
                    13'($urandom_range(4096, 8190)), 2'($urandom_range(0, 3)), 1'b1);
        push_any_frame(13'd8, 1'b1);
        push_flawed_header(FLAW_LENGTH);
        random_phase(100);
        wait_drained();

        // A lock count of zero: every valid header is locked.
        write_lock_count(4'd0);
        sender_idle_pct = 50;
        receiver_idle_pct = 50;
        random_phase(120);
        wait_drained();

        write_lock_count(4'($urandom_range(2, 14)));
        sender_idle_pct = 20;
        receiver_idle_pct = 5;
        random_phase(120);
        wait_drained();

        write_lock_count(4'($urandom_range(2, 14)));
        sender_idle_pct = 5;
        receiver_idle_pct = 60;
        random_phase(120);
        wait_drained();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && events_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ adts_frame_sync.f @@
+incdir+design
design/afs_pkg.sv
design/afs_hdr_decode.sv
design/afs_sync_core.sv
design/adts_frame_sync.sv
design/afs_checker.sv
verif/tb_adts_frame_sync.sv
